[src/tat_pkg.sv]
// ----------------------------------------------------------------------------
// tat_pkg
// Shared types and constants of the trusted address table.
// ----------------------------------------------------------------------------
package tat_pkg;

    localparam int TYPE_W      = 7;
    localparam int ADDR_W      = 48;
    localparam int KEY_W       = TYPE_W + ADDR_W;
    localparam int CMD_W       = 2;
    localparam int COUNT_OUT_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the request word
        logic scan;    // step the table scan
        logic commit;  // update table, load the result register
    } tat_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } tat_status_t;

endpackage

[src/tat_if.sv]
// ----------------------------------------------------------------------------
// tat_req_if / tat_rsp_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface tat_req_if;
    import tat_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [TYPE_W-1:0]   address_type;
    logic [ADDR_W-1:0]   device_address;

    modport source (output valid, output command, output address_type,
                    output device_address, input ready);
    modport sink   (input valid, input command, input address_type,
                    input device_address, output ready);
endinterface

interface tat_rsp_if;
    import tat_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   success;
    logic                   newly_added;
    logic [COUNT_OUT_W-1:0] entry_count;

    modport source (output valid, output success, output newly_added,
                    output entry_count, input ready);
    modport sink   (input valid, input success, input newly_added,
                    input entry_count, output ready);
endinterface

[src/tat_ctrl.sv]
// ----------------------------------------------------------------------------
// tat_ctrl
// Sequencer: accept a word, run the table scan, commit the result.
// ----------------------------------------------------------------------------
module tat_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  tat_pkg::tat_status_t status,
    output tat_pkg::tat_cmd_t    cmd
);
    import tat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.scan_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign req_ready  = ready_reg;
    assign cmd.load   = ready_reg && req_valid;
    assign cmd.scan   = (state_reg == S_SCAN);
    assign cmd.commit = (state_reg == S_RESP) && status.out_free;

endmodule

[src/tat_datapath.sv]
// ----------------------------------------------------------------------------
// tat_datapath
// Entry memory, count, one-entry-per-cycle compare and result register.
// ----------------------------------------------------------------------------
module tat_datapath #(
    parameter int MAX_HOSTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tat_pkg::tat_cmd_t                 cmd,
    output tat_pkg::tat_status_t              status,
    input  logic [tat_pkg::CMD_W-1:0]         command,
    input  logic [tat_pkg::TYPE_W-1:0]        address_type,
    input  logic [tat_pkg::ADDR_W-1:0]        device_address,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic                              success,
    output logic                              newly_added,
    output logic [tat_pkg::COUNT_OUT_W-1:0]   entry_count
);
    import tat_pkg::*;

    localparam int CW = $clog2(MAX_HOSTS + 1);
    localparam int IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;

    logic [KEY_W-1:0] host_mem [MAX_HOSTS];

    op_t              op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    idx_reg;
    logic [KEY_W-1:0] rd_data_reg;
    logic             rd_valid_reg;
    logic             hit_reg;

    logic             rsp_valid_reg;
    logic             success_reg;
    logic             newly_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;

    logic             searching;
    logic             rd_en;
    logic             match;
    logic             full;
    logic             wr_en;
    logic             ok;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    assign searching = (op_reg == CMD_LOOKUP) || (op_reg == CMD_ADD);
    assign rd_en     = cmd.scan && searching && !hit_reg && (idx_reg < count_reg);
    assign match     = rd_valid_reg && (rd_data_reg == key_reg);
    assign full      = (count_reg == CW'(MAX_HOSTS));
    assign wr_en     = cmd.commit && (op_reg == CMD_ADD) && !hit_reg && !full;

    always_comb
    begin
        count_next = count_reg;
        ok         = 1'b0;
        case (op_reg)
            CMD_LOOKUP: ok = hit_reg;
            CMD_ADD:
            begin
                ok = hit_reg || !full;
                if (!hit_reg && !full)
                    count_next = count_reg + CW'(1);
            end
            CMD_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            default: ok = 1'b0;
        endcase
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    // entry storage, no reset: read only below the count
    always_ff @(posedge clk)
    begin
        if (wr_en)
            host_mem[count_reg[IW-1:0]] <= key_reg;
        if (rd_en)
            rd_data_reg <= host_mem[idx_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            key_reg <= {address_type, device_address};
        if (cmd.commit)
        begin
            success_reg   <= ok;
            newly_reg     <= wr_en;
            count_out_reg <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= CMD_LOOKUP;
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (cmd.load)
            begin
                op_reg  <= op_t'(command);
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                    idx_reg <= idx_reg + CW'(1);
                if (match)
                    hit_reg <= 1'b1;
            end
            if (cmd.commit)
                count_reg <= count_next;
            if (cmd.commit)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    assign status.scan_done = !searching || hit_reg
                              || ((idx_reg >= count_reg) && !rd_valid_reg);
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    assign rsp_valid   = rsp_valid_reg;
    assign success     = success_reg;
    assign newly_added = newly_reg;
    assign entry_count = count_out_reg;

endmodule

[src/trusted_address_table.sv]
// ----------------------------------------------------------------------------
// trusted_address_table
// Bounded table of trusted (type, address) pairs with lookup, add, clear.
// ----------------------------------------------------------------------------
// Usage notes:
//  - req carries one command word: command (lookup, add, clear), a 7-bit
//    address type and a 48-bit device address. rsp returns one word per
//    command: success, newly_added and the entry count after the command.
//  - One command is worked on at a time, entries compared one per cycle.
//    A lookup or add compares the stored entries in order until one hits
//    or the count is reached; clear, unused codes and an empty table skip
//    the compare. The next word can be accepted as soon as the result
//    word is registered.
//  - An add that misses is appended at the end if room remains; a full
//    table answers success 0 and is left as it was.
//  - The result sits in an output register; the next command can be
//    accepted while it waits. If rsp stalls, that next command holds in
//    its final step until the register frees.
//  - Reset empties the table (count to zero) at once; there is no
//    clearing pass, entries past the count are never read.
// ----------------------------------------------------------------------------
module trusted_address_table #(
    parameter int MAX_HOSTS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    tat_req_if.sink   req,
    tat_rsp_if.source rsp
);
    import tat_pkg::*;

    tat_cmd_t    cmd;
    tat_status_t status;

    // sequencer
    tat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // storage, compare and result register
    tat_datapath #(
        .MAX_HOSTS (MAX_HOSTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .command        (req.command),
        .address_type   (req.address_type),
        .device_address (req.device_address),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .success        (rsp.success),
        .newly_added    (rsp.newly_added),
        .entry_count    (rsp.entry_count)
    );

endmodule

[src/tat_checker.sv]
// ----------------------------------------------------------------------------
// tat_checker
// Port-level checks of the trusted address table, bound to the top level.
// ----------------------------------------------------------------------------
module tat_checker #(
    parameter int MAX_HOSTS = 8
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic                            success,
    input logic                            newly_added,
    input logic [tat_pkg::COUNT_OUT_W-1:0] entry_count
);
    import tat_pkg::*;

    // one command at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a command is in progress");

    a_added_is_success: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && newly_added) |-> success)
        else $error("new entry reported without success");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(entry_count) <= MAX_HOSTS))
        else $error("entry count beyond table size");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result word dropped under stall");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            ($stable(success) && $stable(newly_added) && $stable(entry_count)))
        else $error("result word changed under stall");

endmodule

bind trusted_address_table tat_checker #(
    .MAX_HOSTS (MAX_HOSTS)
) u_tat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .success     (rsp.success),
    .newly_added (rsp.newly_added),
    .entry_count (rsp.entry_count)
);
